[hdl/cbbr_pkg.sv]
// Shared types, constants and register codes of the chirp band bit receiver.
package cbbr_pkg;

    // Field widths
    localparam int MAG_PORT_W = 24;
    localparam int BAND_W     = 9;
    localparam int THR_W      = 24;
    localparam int STR_W      = 10;
    localparam int BYTE_CFG_W = 8;
    localparam int FRAME_W    = 12;
    localparam int BITPOS_W   = 4;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    // Wide enough for offset + bit_period * bit_position at their largest
    localparam int SAMPLE_W   = 13;

    // Parameter defaults
    localparam int BIN_COUNT_DEF       = 512;
    localparam int SAMPLING_OFFSET_DEF = 2;
    localparam int MAGNITUDE_WIDTH_DEF = 24;

    localparam logic [STR_W-1:0] STRENGTH_MAX   = '1;
    localparam logic [7:0]       FIRST_BIT_MASK = 8'b1000_0000;
    localparam int               BITS_PER_BYTE  = 8;

    // Frame levels
    localparam logic [LEVEL_W-1:0] LEVEL_LOW     = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAND_FIRST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LAST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WINDOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN_HIGHS = 3'd7;

    // Register reset values
    localparam logic [BAND_W-1:0]     RST_BAND_FIRST     = 9'd0;
    localparam logic [BAND_W-1:0]     RST_BAND_LAST      = 9'd511;
    localparam logic [THR_W-1:0]      RST_MAG_THRESHOLD  = 24'd0;
    localparam logic [STR_W-1:0]      RST_STRENGTH_HIGH  = 10'd512;
    localparam logic [STR_W-1:0]      RST_STRENGTH_LOW   = 10'd0;
    localparam logic [BYTE_CFG_W-1:0] RST_SYNC_WINDOW    = 8'd8;
    localparam logic [BYTE_CFG_W-1:0] RST_BIT_PERIOD     = 8'd4;
    localparam logic [BYTE_CFG_W-1:0] RST_SYNC_MIN_HIGHS = 8'd4;

    typedef struct packed {
        logic [BAND_W-1:0]     band_first_bin;
        logic [BAND_W-1:0]     band_last_bin;
        logic [THR_W-1:0]      magnitude_threshold;
        logic [STR_W-1:0]      strength_high;
        logic [STR_W-1:0]      strength_low;
        logic [BYTE_CFG_W-1:0] sync_window;
        logic [BYTE_CFG_W-1:0] bit_period;
        logic [BYTE_CFG_W-1:0] sync_min_highs;
    } t_cfg;

    // Closed frame handed from the bin stage to the decoder
    typedef struct packed {
        logic             vld;
        logic [STR_W-1:0] strength;
    } t_frame;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [STR_W-1:0]   strength;
        logic               sync_error;
        logic               byte_done;
        logic [7:0]         received_byte;
    } t_result;

endpackage

[hdl/cbbr_bin_stage.sv]
// Per-bin band check, threshold compare and strength accumulation.
module cbbr_bin_stage #(
    parameter int BIN_COUNT       = cbbr_pkg::BIN_COUNT_DEF,
    parameter int MAGNITUDE_WIDTH = cbbr_pkg::MAGNITUDE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cbbr_pkg::t_cfg                  i_cfg,
    input  logic                            i_accept,
    input  logic [cbbr_pkg::MAG_PORT_W-1:0] i_magnitude,
    input  logic                            i_last_bin,
    input  logic                            i_frame_take,
    output cbbr_pkg::t_frame                o_frame
);

    localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int CMP_W = (BIN_W > cbbr_pkg::BAND_W) ? BIN_W : cbbr_pkg::BAND_W;
    localparam int MW    = cbbr_pkg::MAG_PORT_W;
    localparam logic [MW-1:0] MAG_MASK =
        (MAGNITUDE_WIDTH >= MW) ? {MW{1'b1}} : MW'((64'd1 << MAGNITUDE_WIDTH) - 64'd1);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

    logic [BIN_W-1:0]           r_bin;
    logic [cbbr_pkg::STR_W-1:0] r_acc;
    logic [cbbr_pkg::STR_W-1:0] n_acc;
    logic                       r_frm_vld;
    logic [cbbr_pkg::STR_W-1:0] r_frm_strength;
    logic [CMP_W-1:0]           idx;
    logic                       hit;

    always_comb begin
        idx = CMP_W'(r_bin);
        hit = (idx >= CMP_W'(i_cfg.band_first_bin))
            && (idx <= CMP_W'(i_cfg.band_last_bin))
            && ((i_magnitude & MAG_MASK) > i_cfg.magnitude_threshold);
        n_acc = (hit && (r_acc != cbbr_pkg::STRENGTH_MAX)) ? r_acc + 1'b1 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin     <= '0;
            r_acc     <= '0;
            r_frm_vld <= 1'b0;
        end else begin
            if (i_frame_take) begin
                r_frm_vld <= 1'b0;
            end
            if (i_accept) begin
                if (i_last_bin) begin
                    r_bin     <= '0;
                    r_acc     <= '0;
                    r_frm_vld <= 1'b1;
                end else begin
                    r_bin <= (r_bin == BIN_LAST) ? '0 : r_bin + 1'b1;
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_last_bin) begin
            r_frm_strength <= n_acc;
        end
    end

    assign o_frame.vld      = r_frm_vld;
    assign o_frame.strength = r_frm_strength;

endmodule

[hdl/cbbr_frame_decoder.sv]
// Frame classification, sync check, bit sampling and result register.
module cbbr_frame_decoder #(
    parameter int SAMPLING_OFFSET = cbbr_pkg::SAMPLING_OFFSET_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbbr_pkg::t_cfg    i_cfg,
    input  cbbr_pkg::t_frame  i_frame,
    input  logic              i_fire,
    input  logic              i_out_stall,
    output logic              o_vld,
    output cbbr_pkg::t_result o_res
);

    localparam int FW = cbbr_pkg::FRAME_W;
    localparam int SW = cbbr_pkg::SAMPLE_W;

    logic [FW-1:0]                 r_fc, n_fc;
    logic [FW-1:0]                 r_shc, n_shc;
    logic [cbbr_pkg::BITPOS_W-1:0] r_bp, n_bp;
    logic [7:0]                    r_byte, n_byte;
    logic                          r_vld;
    cbbr_pkg::t_result             r_res, n_res;

    logic [cbbr_pkg::LEVEL_W-1:0]  level;
    logic [SW-1:0]                 offset;
    logic [SW-1:0]                 max_len;
    logic [FW-1:0]                 prod;
    logic                          sample;
    logic                          sync_err;
    logic                          done;

    always_comb begin
        if (i_frame.strength >= i_cfg.strength_high) begin
            level = cbbr_pkg::LEVEL_HIGH;
        end else if (i_frame.strength <= i_cfg.strength_low) begin
            level = cbbr_pkg::LEVEL_LOW;
        end else begin
            level = cbbr_pkg::LEVEL_UNKNOWN;
        end

        offset  = SW'(i_cfg.sync_window) + SW'(SAMPLING_OFFSET);
        max_len = offset + SW'({i_cfg.bit_period, 3'b000});
        prod    = FW'(i_cfg.bit_period) * FW'(r_bp);
        sample  = SW'(r_fc) == (offset + SW'(prod));

        n_fc   = r_fc;
        n_shc  = r_shc;
        n_bp   = r_bp;
        n_byte = r_byte;

        case (level)
            cbbr_pkg::LEVEL_HIGH: begin
                if (SW'(r_fc) < offset) begin
                    n_shc = r_shc + 1'b1;
                end else if (sample) begin
                    if (!r_bp[3]) begin
                        n_byte = r_byte | (cbbr_pkg::FIRST_BIT_MASK >> r_bp[2:0]);
                    end
                    n_bp = r_bp + 1'b1;
                end
                n_fc = r_fc + 1'b1;
            end
            cbbr_pkg::LEVEL_UNKNOWN: begin
                if (sample) begin
                    n_bp = r_bp + 1'b1;
                end
                n_fc = r_fc + 1'b1;
            end
            default: begin
                // LOW holds everything until a frame has started
                if (r_fc != '0) begin
                    n_fc = r_fc + 1'b1;
                    if (sample) begin
                        n_bp = r_bp + 1'b1;
                    end
                end
            end
        endcase

        sync_err = (n_fc >= FW'(i_cfg.sync_window)) && (n_shc < FW'(i_cfg.sync_min_highs));
        if (sync_err) begin
            n_fc  = '0;
            n_shc = '0;
        end

        done = SW'(n_fc) >= max_len;

        n_res.level         = level;
        n_res.strength      = i_frame.strength;
        n_res.sync_error    = sync_err;
        n_res.byte_done     = done;
        n_res.received_byte = done ? n_byte : 8'd0;

        if (done) begin
            n_fc   = '0;
            n_bp   = '0;
            n_shc  = '0;
            n_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc   <= '0;
            r_shc  <= '0;
            r_bp   <= '0;
            r_byte <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (i_fire) begin
                r_fc   <= n_fc;
                r_shc  <= n_shc;
                r_bp   <= n_bp;
                r_byte <= n_byte;
                r_vld  <= 1'b1;
            end else if (!i_out_stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

[hdl/chirp_band_bit_receiver.sv]
// Top level of the chirp band bit receiver: config registers, handshake, stages.
//
// Takes one spectrum magnitude bin per cycle unless stalled, in bin order, with
// i_last_bin set on the final bin of each frame. Bins inside [band_first_bin,
// band_last_bin] whose magnitude is above magnitude_threshold are counted
// (saturating at 1023). Every closed frame yields exactly one result
// transaction: its level (LOW/HIGH/UNKNOWN), the strength count, a sync error
// flag and, once eight sample points have passed, the decoded byte (MSB
// first; zero while byte_done is low). Bins that do not close a frame yield
// nothing. Rate: one bin transaction per cycle sustained while the input is
// not stalled, with no gaps at frame ends. A frame's result passes through
// the bin stage's frame register, then the level classifier and receiver
// update into the result register. The input side only stalls when a closed
// frame cannot move because the result register is full and the output is
// stalled. Configuration writes are single-cycle and must be made while no
// frame is in flight.
module chirp_band_bit_receiver #(
    parameter int BIN_COUNT       = cbbr_pkg::BIN_COUNT_DEF,
    parameter int SAMPLING_OFFSET = cbbr_pkg::SAMPLING_OFFSET_DEF,
    parameter int MAGNITUDE_WIDTH = cbbr_pkg::MAGNITUDE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [cbbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // bin input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cbbr_pkg::MAG_PORT_W-1:0] i_magnitude,
    input  logic                            i_last_bin,
    // frame result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cbbr_pkg::LEVEL_W-1:0]    o_level,
    output logic [cbbr_pkg::STR_W-1:0]      o_strength,
    output logic                            o_sync_error,
    output logic                            o_byte_done,
    output logic [7:0]                      o_received_byte
);

    cbbr_pkg::t_cfg    r_cfg;
    cbbr_pkg::t_frame  frame;
    cbbr_pkg::t_result res;
    logic              out_vld;
    logic              out_free;
    logic              fire;
    logic              in_accept;

    // Config registers, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_first_bin      <= cbbr_pkg::RST_BAND_FIRST;
            r_cfg.band_last_bin       <= cbbr_pkg::RST_BAND_LAST;
            r_cfg.magnitude_threshold <= cbbr_pkg::RST_MAG_THRESHOLD;
            r_cfg.strength_high       <= cbbr_pkg::RST_STRENGTH_HIGH;
            r_cfg.strength_low        <= cbbr_pkg::RST_STRENGTH_LOW;
            r_cfg.sync_window         <= cbbr_pkg::RST_SYNC_WINDOW;
            r_cfg.bit_period          <= cbbr_pkg::RST_BIT_PERIOD;
            r_cfg.sync_min_highs      <= cbbr_pkg::RST_SYNC_MIN_HIGHS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbbr_pkg::REG_BAND_FIRST: begin
                    r_cfg.band_first_bin <= i_cfg_data[cbbr_pkg::BAND_W-1:0];
                end
                cbbr_pkg::REG_BAND_LAST: begin
                    r_cfg.band_last_bin <= i_cfg_data[cbbr_pkg::BAND_W-1:0];
                end
                cbbr_pkg::REG_MAG_THRESHOLD: begin
                    r_cfg.magnitude_threshold <= i_cfg_data[cbbr_pkg::THR_W-1:0];
                end
                cbbr_pkg::REG_STRENGTH_HIGH: begin
                    r_cfg.strength_high <= i_cfg_data[cbbr_pkg::STR_W-1:0];
                end
                cbbr_pkg::REG_STRENGTH_LOW: begin
                    r_cfg.strength_low <= i_cfg_data[cbbr_pkg::STR_W-1:0];
                end
                cbbr_pkg::REG_SYNC_WINDOW: begin
                    r_cfg.sync_window <= i_cfg_data[cbbr_pkg::BYTE_CFG_W-1:0];
                end
                cbbr_pkg::REG_BIT_PERIOD: begin
                    r_cfg.bit_period <= i_cfg_data[cbbr_pkg::BYTE_CFG_W-1:0];
                end
                cbbr_pkg::REG_SYNC_MIN_HIGHS: begin
                    r_cfg.sync_min_highs <= i_cfg_data[cbbr_pkg::BYTE_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Result register can load when empty or being drained this cycle
    assign out_free   = !out_vld || !i_out_stall;
    // A closed frame moves into the decoder whenever the result slot frees up
    assign fire       = frame.vld && out_free;
    // Stall input only while a closed frame is stuck in the frame register
    assign o_in_stall = frame.vld && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    cbbr_bin_stage #(
        .BIN_COUNT       (BIN_COUNT),
        .MAGNITUDE_WIDTH (MAGNITUDE_WIDTH)
    ) u_bin_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (in_accept),
        .i_magnitude  (i_magnitude),
        .i_last_bin   (i_last_bin),
        .i_frame_take (fire),
        .o_frame      (frame)
    );

    cbbr_frame_decoder #(
        .SAMPLING_OFFSET (SAMPLING_OFFSET)
    ) u_frame_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_frame     (frame),
        .i_fire      (fire),
        .i_out_stall (i_out_stall),
        .o_vld       (out_vld),
        .o_res       (res)
    );

    assign o_out_valid     = out_vld;
    assign o_level         = res.level;
    assign o_strength      = res.strength;
    assign o_sync_error    = res.sync_error;
    assign o_byte_done     = res.byte_done;
    assign o_received_byte = res.received_byte;

endmodule

[test/tb_chirp_band_bit_receiver.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the chirp band bit receiver: bin stimulus, frame predictor, checker.
module tb_chirp_band_bit_receiver;
    import cbbr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    // Settle after the last result before any register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_PERCENT  = 26;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam logic [MAG_PORT_W-1:0] MAG_MAX = '1;

    // One bin transaction as queued for the driver
    typedef struct packed {
        logic [MAG_PORT_W-1:0] magnitude;
        logic                  last_bin;
    } t_bin;

    // DUT ports, all inputs known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [MAG_PORT_W-1:0] i_magnitude = '0;
    logic                  i_last_bin  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LEVEL_W-1:0]    o_level;
    logic [STR_W-1:0]      o_strength;
    logic                  o_sync_error;
    logic                  o_byte_done;
    logic [7:0]            o_received_byte;

    // Predictor copy of the registers and of the receiver state
    t_cfg                  rx_cfg;
    logic [BAND_W-1:0]     bin_idx;
    logic [STR_W-1:0]      strength_acc;
    logic [FRAME_W-1:0]    frame_cnt;
    logic [FRAME_W-1:0]    sync_highs;
    logic [BITPOS_W-1:0]   bit_pos;
    logic [7:0]            byte_acc;

    t_bin        pending_bins[$];      // bins waiting for the driver
    t_result     frame_results_q[$];   // predicted frame results, oldest first
    t_bin        next_bin;
    t_result     exp_result;
    int unsigned bins_queued   = 0;
    int unsigned bins_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;
    logic        quiet;

    chirp_band_bit_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_magnitude     (i_magnitude),
        .i_last_bin      (i_last_bin),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_level         (o_level),
        .o_strength      (o_strength),
        .o_sync_error    (o_sync_error),
        .o_byte_done     (o_byte_done),
        .o_received_byte (o_received_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // A long window with no idling on either side, random idling elsewhere
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end
    assign quiet = (cycle_count >= 250) && (cycle_count < 550);

    // Frame predictor: consumes one accepted bin, queues a result when the
    // bin closes a frame.
    task automatic predict_frame_result(input logic [MAG_PORT_W-1:0] mag, input logic last);
        t_result res;
        int      offset;
        int      max_len;
        logic    sample;
        // in-band bin strictly above threshold counts, saturating
        if (bin_idx >= rx_cfg.band_first_bin && bin_idx <= rx_cfg.band_last_bin
            && mag > rx_cfg.magnitude_threshold && strength_acc != STRENGTH_MAX) begin
            strength_acc = strength_acc + 1'b1;
        end
        if (!last) begin
            // overlong frames wrap the bin index
            bin_idx = (int'(bin_idx) + 1 >= BIN_COUNT_DEF) ? '0 : bin_idx + 1'b1;
        end else begin
            res          = '0;
            res.strength = strength_acc;
            strength_acc = '0;
            bin_idx      = '0;

            if (res.strength >= rx_cfg.strength_high) begin
                res.level = LEVEL_HIGH;
            end else if (res.strength <= rx_cfg.strength_low) begin
                res.level = LEVEL_LOW;
            end else begin
                res.level = LEVEL_UNKNOWN;
            end

            offset  = int'(rx_cfg.sync_window) + SAMPLING_OFFSET_DEF;
            max_len = offset + int'(rx_cfg.bit_period) * BITS_PER_BYTE;
            sample  = int'(frame_cnt) == offset + int'(rx_cfg.bit_period) * int'(bit_pos);

            case (res.level)
                LEVEL_HIGH: begin
                    if (int'(frame_cnt) < offset) begin
                        sync_highs = sync_highs + 1'b1;
                    end else if (sample) begin
                        // past bit seven nothing is set, the position still wraps
                        if (bit_pos < BITS_PER_BYTE) begin
                            byte_acc = byte_acc | (FIRST_BIT_MASK >> bit_pos);
                        end
                        bit_pos = bit_pos + 1'b1;
                    end
                    frame_cnt = frame_cnt + 1'b1;
                end
                LEVEL_UNKNOWN: begin
                    if (sample) begin
                        bit_pos = bit_pos + 1'b1;
                    end
                    frame_cnt = frame_cnt + 1'b1;
                end
                LEVEL_LOW: begin
                    // LOW before a frame has started is dropped
                    if (frame_cnt != '0) begin
                        frame_cnt = frame_cnt + 1'b1;
                        if (sample) begin
                            bit_pos = bit_pos + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // sync check keeps bit position and partial byte
            if (frame_cnt >= rx_cfg.sync_window && sync_highs < rx_cfg.sync_min_highs) begin
                frame_cnt      = '0;
                sync_highs     = '0;
                res.sync_error = 1'b1;
            end
            if (int'(frame_cnt) >= max_len) begin
                res.byte_done     = 1'b1;
                res.received_byte = byte_acc;
                frame_cnt         = '0;
                bit_pos           = '0;
                sync_highs        = '0;
                byte_acc          = '0;
            end
            frame_results_q.push_back(res);
        end
    endtask

    task automatic queue_bin(input logic [MAG_PORT_W-1:0] mag, input logic last);
        pending_bins.push_back('{magnitude: mag, last_bin: last});
        bins_queued++;
    endtask

    // Register write at the next edge; predictor copy follows right away since
    // no bin is in flight when this runs.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_BAND_FIRST:     rx_cfg.band_first_bin      = value[BAND_W-1:0];
            REG_BAND_LAST:      rx_cfg.band_last_bin       = value[BAND_W-1:0];
            REG_MAG_THRESHOLD:  rx_cfg.magnitude_threshold = value[THR_W-1:0];
            REG_STRENGTH_HIGH:  rx_cfg.strength_high       = value[STR_W-1:0];
            REG_STRENGTH_LOW:   rx_cfg.strength_low        = value[STR_W-1:0];
            REG_SYNC_WINDOW:    rx_cfg.sync_window         = value[BYTE_CFG_W-1:0];
            REG_BIT_PERIOD:     rx_cfg.bit_period          = value[BYTE_CFG_W-1:0];
            REG_SYNC_MIN_HIGHS: rx_cfg.sync_min_highs      = value[BYTE_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_cfg s);
        write_reg(REG_BAND_FIRST,     s.band_first_bin);
        write_reg(REG_BAND_LAST,      s.band_last_bin);
        write_reg(REG_MAG_THRESHOLD,  s.magnitude_threshold);
        write_reg(REG_STRENGTH_HIGH,  s.strength_high);
        write_reg(REG_STRENGTH_LOW,   s.strength_low);
        write_reg(REG_SYNC_WINDOW,    s.sync_window);
        write_reg(REG_BIT_PERIOD,     s.bit_period);
        write_reg(REG_SYNC_MIN_HIGHS, s.sync_min_highs);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender holds off until every bin is taken and every frame result is back
    task automatic wait_idle();
        while (pending_bins.size() != 0 || bins_accepted != bins_queued
               || frame_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random frames shaped by the current band and threshold: mostly frames
    // meant to land HIGH or LOW, so the receiver syncs and decodes, plus noise.
    task automatic gen_frames(input int bin_target);
        int                    n_bins;
        int                    frame_len;
        int                    kind;
        logic                  in_band;
        logic [MAG_PORT_W-1:0] mag;
        n_bins = 0;
        while (n_bins < bin_target) begin
            kind      = $urandom_range(0, 99);
            frame_len = $urandom_range(1, 3);
            if (kind < 80) begin
                frame_len += int'(rx_cfg.band_last_bin) + 1;
            end
            if (frame_len > 16) begin
                frame_len = 16;
            end
            for (int i = 0; i < frame_len; i++) begin
                in_band = i >= rx_cfg.band_first_bin && i <= rx_cfg.band_last_bin;
                mag     = $urandom;
                if (in_band && kind < 80 && $urandom_range(0, 9) != 0) begin
                    if (kind < 45) begin
                        mag = (rx_cfg.magnitude_threshold == MAG_MAX) ? MAG_MAX :
                              $urandom_range(rx_cfg.magnitude_threshold + 1, MAG_MAX);
                    end else begin
                        mag = $urandom_range(0, rx_cfg.magnitude_threshold);
                    end
                end
                queue_bin(mag, i == frame_len - 1);
            end
            n_bins += frame_len;
        end
    endtask

    // Driver: one bin transaction per accepted handshake; valid and payload
    // hold while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_frame_result(i_magnitude, i_last_bin);
                bins_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bins.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    next_bin = pending_bins.pop_front();
                    i_in_valid  <= 1'b1;
                    i_magnitude <= next_bin.magnitude;
                    i_last_bin  <= next_bin.last_bin;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result transaction against the oldest
    // prediction and drives random output stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frame_results_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected: lvl %0d str %0d sync %0b done %0b byte %02h",
                                 $time, o_level, o_strength, o_sync_error, o_byte_done,
                                 o_received_byte);
                    end
                end else begin
                    exp_result = frame_results_q.pop_front();
                    if (o_level !== exp_result.level || o_strength !== exp_result.strength
                        || o_sync_error !== exp_result.sync_error
                        || o_byte_done !== exp_result.byte_done
                        || o_received_byte !== exp_result.received_byte) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: exp lvl %0d str %0d sync %0b done %0b byte %02h",
                                     $time, exp_result.level, exp_result.strength,
                                     exp_result.sync_error, exp_result.byte_done,
                                     exp_result.received_byte);
                            $display("%0t: got lvl %0d str %0d sync %0b done %0b byte %02h",
                                     $time, o_level, o_strength, o_sync_error, o_byte_done,
                                     o_received_byte);
                        end
                    end
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Stimulus sequence
    initial begin
        t_cfg rand_cfg;

        rx_cfg = '{RST_BAND_FIRST, RST_BAND_LAST, RST_MAG_THRESHOLD, RST_STRENGTH_HIGH,
                   RST_STRENGTH_LOW, RST_SYNC_WINDOW, RST_BIT_PERIOD, RST_SYNC_MIN_HIGHS};
        bin_idx      = '0;
        strength_acc = '0;
        frame_cnt    = '0;
        sync_highs   = '0;
        bit_pos      = '0;
        byte_acc     = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: LOW before any frame is dropped, UNKNOWN
        // frames, then the sync window runs out with no HIGH frame.
        queue_bin('0, 1'b1);
        queue_bin(MAG_MAX, 1'b0);
        queue_bin(24'd1, 1'b1);
        queue_bin('0, 1'b1);
        queue_bin(24'h800000, 1'b1);
        queue_bin('0, 1'b1);
        queue_bin(24'h7FFFFF, 1'b1);
        queue_bin('0, 1'b1);
        queue_bin(24'h555555, 1'b1);
        queue_bin(24'hAAAAAA, 1'b1);
        wait_idle();

        // Directed, narrow band: out-of-band bins, magnitude equal to the
        // threshold does not count, all three levels.
        apply_settings('{9'd1, 9'd2, 24'h000100, 10'd2, 10'd0, 8'd1, 8'd1, 8'd1});
        queue_bin(MAG_MAX, 1'b0);
        queue_bin(24'h000101, 1'b0);
        queue_bin(24'h000101, 1'b1);
        queue_bin(24'h000100, 1'b0);
        queue_bin(24'h000100, 1'b0);
        queue_bin(24'h000100, 1'b1);
        queue_bin(MAG_MAX, 1'b0);
        queue_bin(24'h000101, 1'b0);
        queue_bin(24'h000100, 1'b1);
        queue_bin('0, 1'b0);
        queue_bin(MAG_MAX, 1'b0);
        queue_bin(MAG_MAX, 1'b1);
        wait_idle();

        // Shortest byte timing
        apply_settings('{9'd0, 9'd7, 24'h3A5C1E, 10'd4, 10'd1, 8'd1, 8'd1, 8'd1});
        gen_frames(80);
        wait_idle();

        // No sync requirement
        apply_settings('{9'd2, 9'd5, 24'd0, 10'd3, 10'd0, 8'd3, 8'd2, 8'd0});
        gen_frames(80);
        wait_idle();

        // Empty band: first bin above last bin
        apply_settings('{9'd9, 9'd3, 24'd0, 10'd1, 10'd0, 8'd2, 8'd1, 8'd0});
        gen_frames(20);
        wait_idle();

        // Threshold at full scale, every frame HIGH, widest windows
        apply_settings('{9'd0, 9'd7, 24'hFFFFFF, 10'd0, 10'd512, 8'd255, 8'd255, 8'd255});
        gen_frames(30);
        wait_idle();

        // Random settings; receiver state carries over between them
        repeat (3) begin
            rand_cfg.band_first_bin      = $urandom_range(0, 3);
            rand_cfg.band_last_bin       = $urandom_range(2, 10);
            rand_cfg.magnitude_threshold = $urandom;
            rand_cfg.strength_high       = $urandom_range(1, 6);
            rand_cfg.strength_low        = $urandom_range(0, 4);
            rand_cfg.sync_window         = $urandom_range(1, 6);
            rand_cfg.bit_period          = $urandom_range(1, 3);
            rand_cfg.sync_min_highs      = $urandom_range(0, 6);
            apply_settings(rand_cfg);
            gen_frames(90);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/cbbr_pkg.sv
hdl/cbbr_bin_stage.sv
hdl/cbbr_frame_decoder.sv
hdl/chirp_band_bit_receiver.sv
test/tb_chirp_band_bit_receiver.sv
